// ===== src/column_baseline_obstacle_grouper_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the column baseline obstacle grouper RTL.
// Every macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COLUMN_BASELINE_OBSTACLE_GROUPER_ASSERT_SVH
`define COLUMN_BASELINE_OBSTACLE_GROUPER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define CBOG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define CBOG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/cbog_pkg.sv =====
// ----------------------------------------------------------------------------
// cbog_pkg
// Types and constants shared by the column baseline obstacle grouper.
// ----------------------------------------------------------------------------
`default_nettype none

package cbog_pkg;

  // Baseline row in unsigned Q10.8.
  localparam int BASE_W     = 18;
  localparam int FRAC_W     = 8;
  localparam int ROW_W      = 10;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Result queue depth; one column can push up to three records.
  localparam int FIFO_DEPTH = 8;
  localparam int MAX_PUSH   = 3;

  // Output record kinds.
  localparam logic KIND_REGION  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_HEIGHT = 3'd0,
    CFG_RISE_THRESH  = 3'd1,
    CFG_EMA_ALPHA    = 3'd2,
    CFG_EMPTY_ROW    = 3'd3,
    CFG_JOIN_GAP     = 3'd4,
    CFG_MIN_WIDTH    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0] frame_height;
    logic [9:0] rise_thresh;
    logic [8:0] ema_alpha;
    logic [9:0] empty_row;
    logic [8:0] join_gap;
    logic [9:0] min_width;
  } cfg_t;

  typedef struct packed {
    logic [9:0] boundary_row;
    logic       last_column;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [8:0] region_start;
    logic [8:0] region_end;
    logic [9:0] region_width;
    logic [4:0] region_count;
    logic       last_result;
  } out_t;

  // Records produced by one column, packed from slot 0 upward.
  typedef struct packed {
    logic [1:0]          num;
    out_t [MAX_PUSH-1:0] recs;
  } push_t;

endpackage

`default_nettype wire

// ===== src/cbog_ram.sv =====
// ----------------------------------------------------------------------------
// cbog_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbog_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/cbog_classifier.sv =====
// ----------------------------------------------------------------------------
// cbog_classifier
// Per-column classification, baseline EMA update and region grouping.
// Holds the frame state and produces the records caused by one column.
// ----------------------------------------------------------------------------
`default_nettype none

module cbog_classifier import cbog_pkg::*; #(
  parameter int MAX_COLUMNS = 512,
  parameter int REGION_CAP  = 20
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           fire,
  input  wire in_t                            item,
  input  wire logic [$clog2(MAX_COLUMNS)-1:0] col,
  input  wire logic [BASE_W-1:0]              base,
  input  wire cfg_t                           cfg,
  output      logic [BASE_W-1:0]              ram_wdata,
  output      push_t                          push
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int REG_W = $clog2(REGION_CAP + 1);
  localparam int WID_W = COL_W + 1;
  localparam int GAP_W = (COL_W > 9) ? COL_W : 9;
  localparam int MW_W  = (WID_W > 10) ? WID_W : 10;
  localparam int DIF_W = BASE_W + 2;
  localparam int PRD_W = DIF_W + 10;

  // Frame state.
  logic              ready_r, ready_nxt;
  logic [BASE_W-1:0] last_good_r, last_good_nxt;
  logic              open_r, open_nxt;
  logic [COL_W-1:0]  start_r, start_nxt;
  logic [COL_W-1:0]  end_r, end_nxt;
  logic [REG_W-1:0]  emit_r, emit_nxt;

  logic [9:0]              b;
  logic                    ground;
  logic [BASE_W-1:0]       ng_base;
  logic [BASE_W-1:0]       lg;
  logic signed [11:0]      dev;
  logic                    obstacle;
  logic [8:0]              alpha_sat;
  logic signed [DIF_W-1:0] diff;
  logic signed [PRD_W-1:0] prod;
  logic signed [PRD_W-1:0] q;
  logic signed [PRD_W-1:0] sum;
  logic [BASE_W-1:0]       ema_base;
  logic                    joinable;
  logic [WID_W-1:0]        w1, w2;
  logic                    e1, e2;
  logic                    st_open;
  logic [COL_W-1:0]        st_start, st_end;
  logic [REG_W-1:0]        st_emit, fin_emit;
  out_t                    r1, r2, rs;

  // Classification against the stored baseline.
  always_comb begin
    b        = item.boundary_row;
    ground   = b < cfg.frame_height;
    ng_base  = {cfg.empty_row, {FRAC_W{1'b0}}};
    lg       = (col == '0) ? ng_base : last_good_r;
    dev      = $signed({2'b00, b}) - $signed({2'b00, base[BASE_W-1:FRAC_W]});
    obstacle = ready_r && (!ground || dev > $signed({2'b00, cfg.rise_thresh}));
  end

  // EMA: base + floor(alpha * (b*256 - base) / 256).
  always_comb begin
    alpha_sat = cfg.ema_alpha[8] ? 9'd256 : cfg.ema_alpha;
    diff      = $signed({2'b00, b, {FRAC_W{1'b0}}}) - $signed({2'b00, base});
    prod      = $signed({1'b0, alpha_sat}) * diff;
    q         = prod >>> FRAC_W;
    sum       = $signed({{(PRD_W-BASE_W){1'b0}}, base}) + q;
    ema_base  = sum[BASE_W-1:0];
  end

  // Baseline write data and the running last good value.
  always_comb begin
    if (!ready_r) begin
      ram_wdata = ground ? {b, {FRAC_W{1'b0}}} : ng_base;
    end else if (obstacle) begin
      ram_wdata = lg;
    end else begin
      ram_wdata = ema_base;
    end
    last_good_nxt = (ready_r && !obstacle) ? ema_base : lg;
  end

  // Run grouping for an obstacle column.
  always_comb begin
    joinable = (col >= end_r) && (GAP_W'(col - end_r) <= GAP_W'(cfg.join_gap));
    w1       = WID_W'(end_r) - WID_W'(start_r) + WID_W'(1);
    e1       = obstacle && open_r && !joinable &&
               (MW_W'(w1) >= MW_W'(cfg.min_width)) &&
               (emit_r < REG_W'(REGION_CAP));
    st_open  = open_r;
    st_start = start_r;
    st_end   = end_r;
    if (obstacle) begin
      st_open = 1'b1;
      st_end  = col;
      if (!open_r || !joinable) begin
        st_start = col;
      end
    end
    st_emit = emit_r + REG_W'(e1);
  end

  // Closing the final run on the last column.
  always_comb begin
    w2       = WID_W'(st_end) - WID_W'(st_start) + WID_W'(1);
    e2       = item.last_column && st_open &&
               (MW_W'(w2) >= MW_W'(cfg.min_width)) &&
               (st_emit < REG_W'(REGION_CAP));
    fin_emit = st_emit + REG_W'(e2);
  end

  // Records, packed in emission order.
  always_comb begin
    r1.kind         = KIND_REGION;
    r1.region_start = 9'(start_r);
    r1.region_end   = 9'(end_r);
    r1.region_width = 10'(w1);
    r1.region_count = '0;
    r1.last_result  = !e2 && !item.last_column;

    r2.kind         = KIND_REGION;
    r2.region_start = 9'(st_start);
    r2.region_end   = 9'(st_end);
    r2.region_width = 10'(w2);
    r2.region_count = '0;
    r2.last_result  = !item.last_column;

    rs.kind         = KIND_SUMMARY;
    rs.region_start = '0;
    rs.region_end   = '0;
    rs.region_width = '0;
    rs.region_count = 5'(fin_emit);
    rs.last_result  = 1'b1;

    push.num     = fire ? (2'(e1) + 2'(e2) + 2'(item.last_column)) : 2'd0;
    push.recs[0] = e1 ? r1 : (e2 ? r2 : rs);
    push.recs[1] = e1 ? (e2 ? r2 : rs) : rs;
    push.recs[2] = rs;
  end

  // Next frame state; the last column clears the run bookkeeping.
  always_comb begin
    if (item.last_column) begin
      ready_nxt = 1'b1;
      open_nxt  = 1'b0;
      start_nxt = '0;
      end_nxt   = '0;
      emit_nxt  = '0;
    end else begin
      ready_nxt = ready_r;
      open_nxt  = st_open;
      start_nxt = st_start;
      end_nxt   = st_end;
      emit_nxt  = st_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= 1'b0;
      last_good_r <= '0;
      open_r      <= 1'b0;
      start_r     <= '0;
      end_r       <= '0;
      emit_r      <= '0;
    end else if (fire) begin
      ready_r     <= ready_nxt;
      last_good_r <= last_good_nxt;
      open_r      <= open_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      emit_r      <= emit_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/cbog_out_fifo.sv =====
// ----------------------------------------------------------------------------
// cbog_out_fifo
// Result queue: takes up to three records per cycle, hands out one while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module cbog_out_fifo import cbog_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output      logic  room,
  output      logic  out_valid,
  input  wire logic  out_stall,
  output      out_t  out_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  out_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  // Pointer and count bookkeeping.
  always_comb begin
    pop       = out_valid && !out_stall;
    head_nxt  = head_r + PTR_W'(pop);
    tail_nxt  = tail_r + PTR_W'(push.num);
    count_nxt = count_r + CNT_W'(push.num) - CNT_W'(pop);
    room      = count_r <= CNT_W'(FIFO_DEPTH - MAX_PUSH);
    out_valid = count_r != '0;
    out_data  = mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage; slot i of the push lands at tail + i.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (2'(i) < push.num) begin
        mem[PTR_W'(tail_r + PTR_W'(i))] <= push.recs[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/column_baseline_obstacle_grouper.sv =====
// The first record of a column passes the compute stage register and the result queue before
// out_valid offers it. Throughput: one column per cycle while the queue has room; further
// records of a column leave one per cycle unless out_stall holds them. A last column with three
// records can hold in_stall as the queue drains; input backs up when out_stall fills the queue.
// Reset is synchronous: it clears control state and restores register defaults;
// the baseline memory is not cleared, the first frame after reset loads it.
// ----------------------------------------------------------------------------
// column_baseline_obstacle_grouper
// Tracks a per-column ground baseline and reports runs of obstacle columns.
// ----------------------------------------------------------------------------
`default_nettype none

`include "column_baseline_obstacle_grouper_assert.svh"

module column_baseline_obstacle_grouper import cbog_pkg::*; #(
  parameter int MAX_COLUMNS = 512,
  parameter int REGION_CAP  = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire in_t                   in_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      out_t                  out_data,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W = $clog2(MAX_COLUMNS);

  cfg_t              cfg_r;
  logic              in_accept;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              s1_valid_r;
  in_t               s1_item_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_fire;
  logic              fwd_r;
  logic [BASE_W-1:0] fwd_data_r;
  logic [BASE_W-1:0] ram_rdata;
  logic [BASE_W-1:0] ram_wdata;
  logic [BASE_W-1:0] base;
  logic              room;
  push_t             push;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_height <= 10'd240;
      cfg_r.rise_thresh  <= 10'd20;
      cfg_r.ema_alpha    <= 9'd26;
      cfg_r.empty_row    <= 10'd0;
      cfg_r.join_gap     <= 9'd3;
      cfg_r.min_width    <= 10'd5;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata;
        CFG_RISE_THRESH:  cfg_r.rise_thresh  <= cfg_wdata;
        CFG_EMA_ALPHA:    cfg_r.ema_alpha    <= cfg_wdata[8:0];
        CFG_EMPTY_ROW:    cfg_r.empty_row    <= cfg_wdata;
        CFG_JOIN_GAP:     cfg_r.join_gap     <= cfg_wdata[8:0];
        CFG_MIN_WIDTH:    cfg_r.min_width    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input handshake: the compute stage advances when the queue has room.
  always_comb begin
    s1_fire   = s1_valid_r && room;
    in_stall  = s1_valid_r && !room;
    in_accept = in_valid && !in_stall;
    if (in_data.last_column || col_r == COL_W'(MAX_COLUMNS - 1)) begin
      col_nxt = '0;
    end else begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  // Column counter and the compute stage input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r <= col_nxt;
        fwd_r <= s1_fire && (s1_col_r == col_r);
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r  <= in_data;
      s1_col_r   <= col_r;
      fwd_data_r <= ram_wdata;
    end
  end

  // Baseline store, read as a column enters and written as it completes.
  cbog_ram #(
    .WIDTH (BASE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_baseline (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // A column read in the same cycle its entry is written takes the new value.
  assign base = fwd_r ? fwd_data_r : ram_rdata;

  cbog_classifier #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .REGION_CAP  (REGION_CAP)
  ) u_classifier (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .item      (s1_item_r),
    .col       (s1_col_r),
    .base      (base),
    .cfg       (cfg_r),
    .ram_wdata (ram_wdata),
    .push      (push)
  );

  cbog_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The input only backs up behind a column waiting in the compute stage.
  `CBOG_ASSERT_IMPL(a_stall_needs_item, in_stall, s1_valid_r, "stall without pending column")
  // A summary record always closes the records of its column.
  `CBOG_ASSERT_IMPL(a_summary_last, out_valid && out_data.kind == KIND_SUMMARY,
                    out_data.last_result, "summary not marked last")
  // Nothing is offered in the cycle after reset.
  `CBOG_ASSERT_ALWAYS(a_reset_empty, !$past(rst_n) |-> !out_valid, "output valid after reset")

endmodule

`default_nettype wire
